// ----- design/tnl_pkg.sv -----
// Shared types, codes and sizes for the tunnel endpoint match table.
// No dependencies.
`timescale 1ns / 1ps

package tnl_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_SET_UP = 2'd2;
  localparam kind_t KIND_LOOKUP = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BAD_ADDR  = 3'd1;
  localparam status_t ST_LINKLOCAL = 3'd2;
  localparam status_t ST_DUP       = 3'd3;
  localparam status_t ST_FULL      = 3'd4;
  localparam status_t ST_MISS      = 3'd5;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] local_hi;
    logic [63:0] local_lo;
    logic [63:0] remote_hi;
    logic [63:0] remote_lo;
    logic [31:0] iif;
    logic [3:0]  handle;
    logic        up_flag;
    status_t     pre_status;
  } cmd_t;

  typedef struct packed {
    logic [63:0] lh;
    logic [63:0] ll;
    logic [63:0] rh;
    logic [63:0] rl;
    logic [31:0] link;
  } tun_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] entry;
    status_t    status;
  } res_t;

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_DRAIN, B_FIN} bstate_t;

endpackage

// ----- design/tnl_front.sv -----
// Front end: classifies an incoming item and screens insert addresses.
// Depends on tnl_pkg.
`timescale 1ns / 1ps

module tnl_front import tnl_pkg::*; (
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_local_hi,
  input  logic [63:0] in_local_lo,
  input  logic [63:0] in_remote_hi,
  input  logic [63:0] in_remote_lo,
  input  logic [31:0] in_interface_index,
  input  logic [3:0]  in_handle,
  input  logic        in_up_flag,
  output cmd_t        cmd
);

  logic bad_addr;
  logic link_local;

  always_comb begin
    bad_addr = (in_local_hi == 64'd0 && in_local_lo == 64'd0) ||
               (in_remote_hi == 64'd0 && in_remote_lo == 64'd0) ||
               (in_remote_hi[63:56] == 8'hFF);
    link_local = ((in_local_hi[63:54] == 10'h3FA) || (in_remote_hi[63:54] == 10'h3FA)) &&
                 (in_interface_index == 32'd0);
    cmd.kind       = in_kind;
    cmd.local_hi   = in_local_hi;
    cmd.local_lo   = in_local_lo;
    cmd.remote_hi  = in_remote_hi;
    cmd.remote_lo  = in_remote_lo;
    cmd.iif        = in_interface_index;
    cmd.handle     = in_handle;
    cmd.up_flag    = in_up_flag;
    cmd.pre_status = ST_OK;
    if (in_kind == KIND_INSERT) begin
      if (bad_addr) begin
        cmd.pre_status = ST_BAD_ADDR;
      end else if (link_local) begin
        cmd.pre_status = ST_LINKLOCAL;
      end
    end
  end

endmodule

// ----- design/tnl_cmdq.sv -----
// Two-deep command queue between front end and table engine.
// Depends on tnl_pkg.
`timescale 1ns / 1ps

module tnl_cmdq import tnl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rdata
);

  cmd_t       mem [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/tnl_back.sv -----
// Table engine: holds the tunnel table, scans it one entry a cycle,
// applies updates and keeps the result register. Depends on tnl_pkg.
`timescale 1ns / 1ps

module tnl_back import tnl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  cmd_t    q_cmd,
  output logic    q_pop,
  input  logic    res_pop,
  output logic    res_empty,
  output res_t    res
);

  bstate_t state_r, state_nxt;

  tun_t                   mem [TABLE_ENTRIES];
  tun_t                   rd_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] up_r;
  logic [IDX_W-1:0]       rank_r [TABLE_ENTRIES];

  cmd_t             cmd_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             cmp_v_r;
  logic [IDX_W-1:0] cmp_idx_r;

  logic             ex_hit_r;
  logic [IDX_W-1:0] ex_idx_r;
  logic [IDX_W-1:0] ex_rank_r;
  logic [1:0]       rm_cnt_r, lc_cnt_r, any_cnt_r;
  logic [IDX_W-1:0] rm_idx_r, lc_idx_r, any_idx_r;
  logic             dup_r;

  logic             res_v_r;
  res_t             res_r, res_nxt;

  logic             start;
  logic             last_rd;
  logic             fin;
  logic             c_v, c_up, c_lok, c_elig, c_rm, c_lc, c_ex;
  logic [IDX_W-1:0] c_rank;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] hidx;
  logic             hdl_ok;
  logic             do_ins, do_rem, do_set;

  assign start     = (state_r == B_IDLE) && !q_empty && !res_v_r;
  assign q_pop     = start;
  assign last_rd   = (rd_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign fin       = (state_r == B_FIN);
  assign res_empty = !res_v_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (start) begin
          if (q_cmd.kind == KIND_REMOVE || q_cmd.kind == KIND_SET_UP ||
              q_cmd.pre_status != ST_OK) begin
            state_nxt = B_FIN;
          end else begin
            state_nxt = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (last_rd) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: state_nxt = B_FIN;
      B_FIN:   state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // compare stage
  always_comb begin
    c_v    = valid_r[cmp_idx_r];
    c_up   = up_r[cmp_idx_r];
    c_rank = rank_r[cmp_idx_r];
    c_lok  = (rd_r.link == 32'd0) || (rd_r.link == cmd_r.iif);
    c_rm   = (rd_r.rh == cmd_r.remote_hi) && (rd_r.rl == cmd_r.remote_lo);
    c_lc   = (rd_r.lh == cmd_r.local_hi) && (rd_r.ll == cmd_r.local_lo);
    c_ex   = c_rm && c_lc;
    c_elig = cmp_v_r && c_v && c_up && c_lok;
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    hidx    = IDX_W'(cmd_r.handle);
    hdl_ok  = ({28'd0, cmd_r.handle} < 32'(TABLE_ENTRIES)) && valid_r[hidx];
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_set  = 1'b0;
    res_nxt = '{hit: 1'b0, entry: 4'd0, status: ST_MISS};
    case (cmd_r.kind)
      KIND_INSERT: begin
        if (cmd_r.pre_status != ST_OK) begin
          res_nxt.status = cmd_r.pre_status;
        end else if (dup_r) begin
          res_nxt.status = ST_DUP;
        end else if (!free_found) begin
          res_nxt.status = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          res_nxt = '{hit: 1'b1, entry: 4'(free_idx), status: ST_OK};
        end
      end
      KIND_REMOVE, KIND_SET_UP: begin
        if (hdl_ok) begin
          do_rem  = (cmd_r.kind == KIND_REMOVE);
          do_set  = (cmd_r.kind == KIND_SET_UP);
          res_nxt = '{hit: 1'b1, entry: cmd_r.handle, status: ST_OK};
        end
      end
      default: begin
        if (ex_hit_r) begin
          res_nxt = '{hit: 1'b1, entry: 4'(ex_idx_r), status: ST_OK};
        end else if (rm_cnt_r == 2'd1) begin
          res_nxt = '{hit: 1'b1, entry: 4'(rm_idx_r), status: ST_OK};
        end else if (lc_cnt_r == 2'd1) begin
          res_nxt = '{hit: 1'b1, entry: 4'(lc_idx_r), status: ST_OK};
        end else if (any_cnt_r == 2'd1) begin
          res_nxt = '{hit: 1'b1, entry: 4'(any_idx_r), status: ST_OK};
        end
      end
    endcase
  end

  // table storage
  always_ff @(posedge clk) begin
    if (fin && do_ins) begin
      mem[free_idx] <= '{lh: cmd_r.local_hi, ll: cmd_r.local_lo, rh: cmd_r.remote_hi,
                         rl: cmd_r.remote_lo, link: cmd_r.iif};
    end
    if (state_r == B_SCAN) begin
      rd_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (fin && do_ins) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (valid_r[i]) begin
          rank_r[i] <= rank_r[i] + IDX_W'(1);
        end
      end
      rank_r[free_idx] <= '0;
    end else if (fin && do_rem) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (valid_r[i] && rank_r[i] > rank_r[hidx]) begin
          rank_r[i] <= rank_r[i] - IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      up_r    <= '0;
    end else if (fin) begin
      if (do_ins) begin
        valid_r[free_idx] <= 1'b1;
        up_r[free_idx]    <= 1'b0;
      end
      if (do_rem) begin
        valid_r[hidx] <= 1'b0;
        up_r[hidx]    <= 1'b0;
      end
      if (do_set) begin
        up_r[hidx] <= cmd_r.up_flag;
      end
    end
  end

  // scan control and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r  <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      cmp_v_r <= (state_r == B_SCAN);
      if (start) begin
        rd_idx_r <= '0;
      end else if (state_r == B_SCAN && !last_rd) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx_r;
    if (start) begin
      cmd_r     <= q_cmd;
      ex_hit_r  <= 1'b0;
      dup_r     <= 1'b0;
      rm_cnt_r  <= 2'd0;
      lc_cnt_r  <= 2'd0;
      any_cnt_r <= 2'd0;
    end else if (cmp_v_r) begin
      if (c_v && c_lok && c_ex) begin
        dup_r <= 1'b1;
      end
      if (c_elig && c_ex && (!ex_hit_r || c_rank < ex_rank_r)) begin
        ex_hit_r  <= 1'b1;
        ex_idx_r  <= cmp_idx_r;
        ex_rank_r <= c_rank;
      end
      if (c_elig && c_rm) begin
        rm_cnt_r <= (rm_cnt_r == 2'd0) ? 2'd1 : 2'd2;
        rm_idx_r <= cmp_idx_r;
      end
      if (c_elig && c_lc) begin
        lc_cnt_r <= (lc_cnt_r == 2'd0) ? 2'd1 : 2'd2;
        lc_idx_r <= cmp_idx_r;
      end
      if (c_elig) begin
        any_cnt_r <= (any_cnt_r == 2'd0) ? 2'd1 : 2'd2;
        any_idx_r <= cmp_idx_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (fin) begin
      res_v_r <= 1'b1;
    end else if (res_pop && res_v_r) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- design/tunnel_endpoint_match_table_unit.sv -----
// Top level of the tunnel endpoint match table: front end, command queue,
// table engine. Depends on tnl_pkg, tnl_front, tnl_cmdq and tnl_back.
`timescale 1ns / 1ps

// Items enter through a two-deep queue and are handled one at a time.
// Remove, set-up and rejected inserts go from queue head straight to the
// finish state; inserts and lookups walk the table one entry per cycle over
// its single read port, then pass through the drain and finish states.
// A finished result sits in an output register until popped; the next
// item starts once that register is empty.

module tunnel_endpoint_match_table_unit import tnl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_local_hi,
  input  logic [63:0] in_local_lo,
  input  logic [63:0] in_remote_hi,
  input  logic [63:0] in_remote_lo,
  input  logic [31:0] in_interface_index,
  input  logic [3:0]  in_handle,
  input  logic        in_up_flag,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_hit,
  output logic [3:0]  out_entry,
  output logic [2:0]  out_status
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;
  res_t res;

  tnl_front u_front (
    .in_kind            (in_kind),
    .in_local_hi        (in_local_hi),
    .in_local_lo        (in_local_lo),
    .in_remote_hi       (in_remote_hi),
    .in_remote_lo       (in_remote_lo),
    .in_interface_index (in_interface_index),
    .in_handle          (in_handle),
    .in_up_flag         (in_up_flag),
    .cmd                (front_cmd)
  );

  tnl_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_cmd)
  );

  tnl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (res)
  );

  assign out_hit    = res.hit;
  assign out_entry  = res.entry;
  assign out_status = res.status;

endmodule

// ----- sim/tnl_checker.sv -----
// Checker for the tunnel endpoint match table: watches both queue ports,
// predicts each result from its own copy of the table and compares.
// Depends on tnl_pkg.
`timescale 1ns / 1ps

module tnl_checker import tnl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_local_hi,
  input  logic [63:0] in_local_lo,
  input  logic [63:0] in_remote_hi,
  input  logic [63:0] in_remote_lo,
  input  logic [31:0] in_interface_index,
  input  logic [3:0]  in_handle,
  input  logic        in_up_flag,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic        out_hit,
  input  logic [3:0]  out_entry,
  input  logic [2:0]  out_status,
  output int          fail_count,
  output int          pending
);

  logic        tv_valid [TABLE_ENTRIES];
  logic        tv_up    [TABLE_ENTRIES];
  tun_t        tv_tun   [TABLE_ENTRIES];
  int unsigned tv_rank  [TABLE_ENTRIES];
  res_t        expected_results[$];

  function automatic bit link_ll(logic [63:0] hi);
    return hi[63:54] == 10'h3FA;
  endfunction

  function automatic bit usable(int i, logic [31:0] iif);
    return tv_valid[i] && tv_up[i] && (tv_tun[i].link == 0 || tv_tun[i].link == iif);
  endfunction

  // mode 0 remote only, 1 local only, 2 interface only
  function automatic int unique_tunnel(int mode, logic [63:0] lh, logic [63:0] ll,
                                       logic [63:0] rh, logic [63:0] rl,
                                       logic [31:0] iif);
    int found;
    found = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!usable(i, iif)) continue;
      if (mode == 0 && (tv_tun[i].rh != rh || tv_tun[i].rl != rl)) continue;
      if (mode == 1 && (tv_tun[i].lh != lh || tv_tun[i].ll != ll)) continue;
      if (found >= 0) return -1;
      found = i;
    end
    return found;
  endfunction

  function automatic res_t apply_item(kind_t k, logic [63:0] lh, logic [63:0] ll,
                                      logic [63:0] rh, logic [63:0] rl,
                                      logic [31:0] iif, logic [3:0] h, logic upv);
    res_t r;
    int slot;
    int best;
    int unsigned rk;
    r = '{hit: 1'b0, entry: 4'd0, status: ST_MISS};
    case (k)
      KIND_INSERT: begin
        if ((lh == 0 && ll == 0) || (rh == 0 && rl == 0) || rh[63:56] == 8'hFF) begin
          r.status = ST_BAD_ADDR;
          return r;
        end
        if ((link_ll(lh) || link_ll(rh)) && iif == 0) begin
          r.status = ST_LINKLOCAL;
          return r;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (tv_valid[i] && (tv_tun[i].link == 0 || tv_tun[i].link == iif) &&
              tv_tun[i].lh == lh && tv_tun[i].ll == ll &&
              tv_tun[i].rh == rh && tv_tun[i].rl == rl) begin
            r.status = ST_DUP;
            return r;
          end
        slot = -1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
          if (!tv_valid[i]) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
          return r;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (tv_valid[i]) tv_rank[i]++;
        tv_valid[slot] = 1'b1;
        tv_up[slot] = 1'b0;
        tv_tun[slot] = '{lh: lh, ll: ll, rh: rh, rl: rl, link: iif};
        tv_rank[slot] = 0;
        r = '{hit: 1'b1, entry: 4'(slot), status: ST_OK};
      end
      KIND_REMOVE, KIND_SET_UP: begin
        if (h >= TABLE_ENTRIES || !tv_valid[h]) return r;
        if (k == KIND_REMOVE) begin
          rk = tv_rank[h];
          tv_valid[h] = 1'b0;
          tv_up[h] = 1'b0;
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tv_valid[i] && tv_rank[i] > rk) tv_rank[i]--;
        end else begin
          tv_up[h] = upv;
        end
        r = '{hit: 1'b1, entry: h, status: ST_OK};
      end
      default: begin
        best = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (usable(i, iif) && tv_tun[i].lh == lh && tv_tun[i].ll == ll &&
              tv_tun[i].rh == rh && tv_tun[i].rl == rl &&
              (best < 0 || tv_rank[i] < tv_rank[best]))
            best = i;
        for (int m = 0; m < 3 && best < 0; m++)
          best = unique_tunnel(m, lh, ll, rh, rl, iif);
        if (best >= 0) r = '{hit: 1'b1, entry: 4'(best), status: ST_OK};
      end
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      fail_count <= 0;
      expected_results.delete();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tv_valid[i] = 1'b0;
        tv_up[i] = 1'b0;
        tv_rank[i] = 0;
      end
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected item: hit=%0d entry=%0d status=%0d",
                     out_hit, out_entry, out_status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.hit !== out_hit || want.entry !== out_entry ||
              want.status !== out_status) begin
            if (fail_count < 10)
              $display("mismatch: expected hit=%0d entry=%0d status=%0d, got %0d %0d %0d",
                       want.hit, want.entry, want.status, out_hit, out_entry, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_push && !in_full)
        expected_results.push_back(apply_item(in_kind, in_local_hi, in_local_lo,
                                              in_remote_hi, in_remote_lo,
                                              in_interface_index, in_handle,
                                              in_up_flag));
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the tunnel endpoint match table: drives items and pops
// results with random idling, and gives the verdict. Depends on tnl_pkg,
// tnl_checker and the block.
`timescale 1ns / 1ps

module tb import tnl_pkg::*;;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_kind;
  logic [63:0] in_local_hi, in_local_lo, in_remote_hi, in_remote_lo;
  logic [31:0] in_interface_index;
  logic [3:0]  in_handle;
  logic        in_up_flag;
  logic        out_empty;
  logic        out_pop;
  logic        out_hit;
  logic [3:0]  out_entry;
  logic [2:0]  out_status;
  int          fail_count;
  int          pending;
  bit          calm;
  bit          hold_results;
  int          idle_cycles;

  // small pools so that matches, duplicates and fallbacks happen often
  logic [63:0] addr_pool [8];
  logic [31:0] link_pool [4];

  tunnel_endpoint_match_table_unit uut (.*);
  tnl_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send(kind_t k, logic [63:0] lh, logic [63:0] ll, logic [63:0] rh,
                      logic [63:0] rl, logic [31:0] iif, logic [3:0] h, logic upv);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_kind <= k;
    in_local_hi <= lh;
    in_local_lo <= ll;
    in_remote_hi <= rh;
    in_remote_lo <= rl;
    in_interface_index <= iif;
    in_handle <= h;
    in_up_flag <= upv;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_hi();
    case ($urandom_range(0, 9))
      0: return {10'h3FA, 54'($urandom())};
      1: return {8'hFF, 56'({$urandom(), $urandom()})};
      2: return 64'd0;
      3: return {$urandom(), $urandom()};
      default: return addr_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [63:0] pick_lo();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return {$urandom(), $urandom()};
      default: return addr_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  task automatic random_item();
    kind_t k;
    logic [31:0] iif;
    case ($urandom_range(0, 9))
      0, 1, 2: k = KIND_INSERT;
      3:       k = KIND_REMOVE;
      4, 5:    k = KIND_SET_UP;
      default: k = KIND_LOOKUP;
    endcase
    iif = ($urandom_range(0, 7) == 0) ? $urandom() : link_pool[$urandom_range(0, 3)];
    send(k, pick_hi(), pick_lo(), pick_hi(), pick_lo(), iif,
         4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  // receiver: random stalls, one long hold-off, none in the calm tail
  initial begin
    int gap;
    out_pop = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_results) begin
        out_pop <= 1'b0;
        repeat (200) @(posedge clk);
        hold_results = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 10);
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0] a, b;
    calm = 1'b0;
    hold_results = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_kind = KIND_INSERT;
    in_local_hi = '0;
    in_local_lo = '0;
    in_remote_hi = '0;
    in_remote_lo = '0;
    in_interface_index = '0;
    in_handle = '0;
    in_up_flag = 1'b0;
    for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom(), $urandom()} | 64'd1;
    addr_pool[0][63:56] = 8'h20;
    addr_pool[1][63:56] = 8'h3F;
    for (int i = 0; i < 4; i++) link_pool[i] = 32'(i);
    link_pool[3] = 32'hFFFF_FFFF;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    a = addr_pool[0];
    b = addr_pool[1];
    // directed: address checks, duplicate, handles, lookup phases
    send(KIND_LOOKUP, a, a, b, b, 0, 0, 0);
    send(KIND_INSERT, 0, 0, b, b, 0, 0, 0);
    send(KIND_INSERT, a, a, 0, 0, 0, 0, 0);
    send(KIND_INSERT, a, a, 64'hFF02_0000_0000_0000, 1, 0, 0, 0);
    send(KIND_INSERT, 64'hFE80_0000_0000_0000, 1, b, b, 0, 0, 0);
    send(KIND_INSERT, a, a, 64'hFEBF_FFFF_FFFF_FFFF, 1, 0, 0, 0);
    send(KIND_INSERT, 64'hFE80_0000_0000_0000, 1, b, b, 32'hFFFF_FFFF, 0, 1);
    send(KIND_INSERT, a, a, b, b, 0, 0, 0);
    send(KIND_INSERT, a, a, b, b, 7, 0, 0);
    send(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
         64'hFEFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5, 0, 0);
    send(KIND_LOOKUP, a, a, b, b, 0, 0, 0);
    send(KIND_SET_UP, 0, 0, 0, 0, 0, 4'd1, 1'b1);
    send(KIND_SET_UP, 0, 0, 0, 0, 0, 4'd2, 1'b1);
    send(KIND_LOOKUP, a, a, b, b, 0, 0, 0);
    send(KIND_LOOKUP, 1, 2, b, b, 9, 0, 0);
    send(KIND_LOOKUP, a, a, 3, 4, 9, 0, 0);
    send(KIND_LOOKUP, 1, 2, 3, 4, 5, 0, 0);
    send(KIND_SET_UP, 0, 0, 0, 0, 0, 4'd15, 1'b1);
    send(KIND_REMOVE, 0, 0, 0, 0, 0, 4'd15, 1'b0);
    send(KIND_REMOVE, 0, 0, 0, 0, 0, 4'd1, 1'b0);
    send(KIND_REMOVE, 0, 0, 0, 0, 0, 4'd1, 1'b0);
    for (int i = 0; i < 17; i++)
      send(KIND_INSERT, a, 64'(i + 100), b, b, 0, 0, 0);

    hold_results = 1'b1;
    for (int n = 0; n < 1300; n++) begin
      if (n == 1100) calm = 1'b1;
      random_item();
    end
    in_push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
